/* rtl/core/vertex_dedup_table_defines.svh */
// Assertion macros shared by the checker files of the vertex dedup table.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef VERTEX_DEDUP_TABLE_DEFINES_SVH
`define VERTEX_DEDUP_TABLE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define VDT_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define VDT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/vdt_pkg.sv */
// Package of the vertex dedup table: table size, widths, key and link types, FSM states.
// Depends on nothing; every file of the block but the macro header imports it.
`default_nettype none

package vdt_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int KEY_WORDS  = 8;
   localparam int WORD_W     = 32;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam int VIDX_W     = 8;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(TABLE_SIZE - 1);
   localparam logic [WORD_W-1:0] NEG_ZERO  = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [0:0] {
      REG_USE_NORMAL   = 1'b0,
      REG_USE_TEXCOORD = 1'b1
   } vdt_reg_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] vdt_key_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } vdt_link_type;

   typedef struct packed {
      logic             load;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [CNT_W-1:0] count;
   } vdt_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } vdt_state_type;

   function automatic logic [WORD_W-1:0] canon_word(input logic [WORD_W-1:0] w);
      return (w == NEG_ZERO) ? '0 : w;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/vdt_req_if.sv */
// Input channel of the vertex dedup table: valid, ready and one vertex beat.
// Depends on vdt_pkg for the word width.
`default_nettype none

interface vdt_req_if import vdt_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              new_mesh;
   logic [WORD_W-1:0] pos_x;
   logic [WORD_W-1:0] pos_y;
   logic [WORD_W-1:0] pos_z;
   logic [WORD_W-1:0] norm_x;
   logic [WORD_W-1:0] norm_y;
   logic [WORD_W-1:0] norm_z;
   logic [WORD_W-1:0] tex_u;
   logic [WORD_W-1:0] tex_v;

   modport source (output valid, new_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   tex_u, tex_v, input ready);
   modport sink (input valid, new_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 tex_u, tex_v, output ready);
   modport monitor (input valid, ready, new_mesh, pos_x, pos_y, pos_z, norm_x, norm_y,
                    norm_z, tex_u, tex_v);
endinterface

`default_nettype wire

/* rtl/core/vdt_rsp_if.sv */
// Result channel of the vertex dedup table: valid, ready and one index beat.
// Depends on vdt_pkg for the index width.
`default_nettype none

interface vdt_rsp_if import vdt_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [VIDX_W-1:0] vertex_index;
   logic              was_new;
   logic              table_full;

   modport source (output valid, vertex_index, was_new, table_full, input ready);
   modport sink (input valid, vertex_index, was_new, table_full, output ready);
   modport monitor (input valid, ready, vertex_index, was_new, table_full);
endinterface

`default_nettype wire

/* rtl/core/vdt_cell.sv */
// One table entry: stores a vertex key, compares it with the broadcast key and
// passes the first-hit link to its neighbor. Depends on vdt_pkg.
`default_nettype none

module vdt_cell import vdt_pkg::*; (
   input  wire logic         clock,
   input  wire logic [IDX_W-1:0] my_idx,
   input  wire vdt_key_type  key,
   input  wire vdt_ctl_type  ctl,
   input  wire vdt_link_type link_prev,
   output vdt_link_type      link_next
);

   vdt_key_type  entry_ff;
   vdt_link_type link_ff;
   vdt_link_type link_in;
   logic         active;
   logic         match;

   assign active = CNT_W'(my_idx) < ctl.count;
   assign match  = active && (entry_ff == key);

   always_comb begin
      link_in.hit = link_prev.hit || match;
      link_in.idx = link_prev.hit ? link_prev.idx : my_idx;
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en && (ctl.wr_idx == my_idx)) begin
         entry_ff <= key;
      end
      link_ff <= link_in;
   end

   assign link_next = link_ff;

endmodule

`default_nettype wire

/* rtl/core/vdt_csr.sv */
// Configuration registers use_normal and use_texcoord behind an APB-style port.
// Depends on vdt_pkg for the register codes and bus widths.
`default_nettype none

module vdt_csr import vdt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready,
   output logic                   use_normal,
   output logic                   use_texcoord
);

   vdt_reg_type reg_sel;
   logic        wr_go;
   logic        use_normal_ff;
   logic        use_normal_in;
   logic        use_texcoord_ff;
   logic        use_texcoord_in;

   assign reg_sel    = vdt_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_go      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      use_normal_in   = use_normal_ff;
      use_texcoord_in = use_texcoord_ff;
      if (wr_go) begin
         unique case (reg_sel)
            REG_USE_NORMAL:   use_normal_in   = csr_pwdata[0];
            REG_USE_TEXCOORD: use_texcoord_in = csr_pwdata[0];
            default:          use_normal_in   = use_normal_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_USE_NORMAL:   csr_prdata = CSR_DW'(use_normal_ff);
         REG_USE_TEXCOORD: csr_prdata = CSR_DW'(use_texcoord_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_normal_ff   <= 1'b1;
         use_texcoord_ff <= 1'b1;
      end else begin
         use_normal_ff   <= use_normal_in;
         use_texcoord_ff <= use_texcoord_in;
      end
   end

   assign use_normal   = use_normal_ff;
   assign use_texcoord = use_texcoord_ff;

endmodule

`default_nettype wire

/* rtl/core/vdt_ctrl.sv */
// Sequencer of the vertex dedup table: input handshake, search timing, entry count,
// table writes and the result register. Depends on vdt_pkg.
`default_nettype none

module vdt_ctrl import vdt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_new_mesh,
   output logic              req_ready,
   input  wire vdt_link_type result,
   output vdt_ctl_type       ctl,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [VIDX_W-1:0] rsp_vertex_index,
   output logic              rsp_was_new,
   output logic              rsp_table_full
);

   vdt_state_type     state_ff;
   vdt_state_type     state_in;
   logic [IDX_W-1:0]  step_ff;
   logic [IDX_W-1:0]  step_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [VIDX_W-1:0] rsp_index_ff;
   logic [VIDX_W-1:0] rsp_index_in;
   logic              rsp_new_ff;
   logic              rsp_new_in;
   logic              rsp_full_ff;
   logic              rsp_full_in;
   logic              slot_free;
   logic              load;
   logic              finish_go;
   logic              full;
   logic              store;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = count_ff == CNT_W'(TABLE_SIZE);
   assign store     = finish_go && !result.hit && !full;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: if (step_ff == LAST_STEP) begin
            state_in = ST_FINISH;
         end
         ST_FINISH: if (slot_free) begin
            state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      load      = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            load      = req_valid;
         end
         ST_SEARCH: begin
            req_ready = 1'b0;
         end
         ST_FINISH: begin
            finish_go = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = (state_ff == ST_SEARCH) ? step_ff + 1'b1 : '0;

      count_in = count_ff;
      if (load && req_new_mesh) begin
         count_in = '0;
      end else if (store) begin
         count_in = count_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      if (finish_go) begin
         priority if (result.hit) begin
            rsp_index_in = VIDX_W'(result.idx);
            rsp_new_in   = 1'b0;
            rsp_full_in  = 1'b0;
         end else if (full) begin
            rsp_index_in = '0;
            rsp_new_in   = 1'b0;
            rsp_full_in  = 1'b1;
         end else begin
            rsp_index_in = VIDX_W'(count_ff);
            rsp_new_in   = 1'b1;
            rsp_full_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
   end

   always_comb begin
      ctl.load   = load;
      ctl.wr_en  = store;
      ctl.wr_idx = count_ff[IDX_W-1:0];
      ctl.count  = count_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_was_new      = rsp_new_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

`default_nettype wire

/* rtl/core/vertex_dedup_table.sv */
// Top level of the vertex dedup table: key capture, the chain of entry cells,
// the sequencer and the configuration registers. Depends on vdt_pkg and the cells.
//
//   channel   direction  handshake              beat
//   req_bus   in         valid/ready            new_mesh, eight 32-bit components
//   rsp_bus   out        valid/ready            vertex_index, was_new, table_full
//   csr_*     in         psel/penable, pready   one register write or read
//
// An input beat is taken only when the block is idle, so the next beat waits until the
// result of the last one is registered; the search time is set by the first-hit link
// rippling through one cell per cycle. A result waiting on rsp_bus stalls only the
// finish of the next vertex.
// Reset empties the table and sets both configuration bits.
`default_nettype none

module vertex_dedup_table import vdt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   vdt_req_if.sink                req_bus,
   vdt_rsp_if.source              rsp_bus,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic         use_normal;
   logic         use_texcoord;
   vdt_ctl_type  ctl;
   vdt_key_type  key_ff;
   vdt_key_type  key_in;
   vdt_link_type link [TABLE_SIZE+1];

   vdt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .use_normal   (use_normal),
      .use_texcoord (use_texcoord)
   );

   always_comb begin
      key_in    = key_ff;
      if (ctl.load) begin
         key_in[0] = canon_word(req_bus.pos_x);
         key_in[1] = canon_word(req_bus.pos_y);
         key_in[2] = canon_word(req_bus.pos_z);
         key_in[3] = use_normal ? canon_word(req_bus.norm_x) : '0;
         key_in[4] = use_normal ? canon_word(req_bus.norm_y) : '0;
         key_in[5] = use_normal ? canon_word(req_bus.norm_z) : '0;
         key_in[6] = use_texcoord ? canon_word(req_bus.tex_u) : '0;
         key_in[7] = use_texcoord ? canon_word(req_bus.tex_v) : '0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign link[0] = '0;

   for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
      vdt_cell u_cell (
         .clock     (clock),
         .my_idx    (IDX_W'(g)),
         .key       (key_ff),
         .ctl       (ctl),
         .link_prev (link[g]),
         .link_next (link[g+1])
      );
   end

   vdt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_new_mesh     (req_bus.new_mesh),
      .req_ready        (req_bus.ready),
      .result           (link[TABLE_SIZE]),
      .ctl              (ctl),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_vertex_index (rsp_bus.vertex_index),
      .rsp_was_new      (rsp_bus.was_new),
      .rsp_table_full   (rsp_bus.table_full)
   );

endmodule

`default_nettype wire

/* rtl/core/vdt_checker.sv */
// Port-level checks of the vertex dedup table, bound to the top level.
// Depends on vdt_pkg and the assertion macro header.
`default_nettype none
`include "vertex_dedup_table_defines.svh"

module vdt_checker import vdt_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [VIDX_W-1:0] rsp_vertex_index,
   input wire logic              rsp_was_new,
   input wire logic              rsp_table_full
);

   logic req_beat;
   logic rsp_stall;
   logic rsp_full;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_full  = rsp_valid && rsp_table_full;

   `VDT_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")
   `VDT_ASSERT_CLK(a_one_in_flight, req_beat |=> !req_ready, "beat taken during a search")
   `VDT_ASSERT_CLK(a_flags_exclusive, rsp_valid |-> !(rsp_was_new && rsp_table_full), "new and full")
   `VDT_ASSERT_CLK(a_full_index_zero, rsp_full |-> (rsp_vertex_index == '0), "full, nonzero index")
   `VDT_ASSERT_CLK(a_rsp_held, rsp_stall |=> rsp_valid, "result beat dropped while stalled")

endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_vertex_index (rsp_bus.vertex_index),
   .rsp_was_new      (rsp_bus.was_new),
   .rsp_table_full   (rsp_bus.table_full)
);

`default_nettype wire

/* verif/tb_vertex_dedup_table.sv */
// Self-checking testbench of the vertex dedup table: directed and random vertex beats,
// register settings over the APB-style port, and a predictor of the welded indexes.
// Depends on vdt_pkg, vdt_req_if, vdt_rsp_if and the vertex_dedup_table RTL.
module tb_vertex_dedup_table;
   import vdt_pkg::*;

   localparam int W_POS_X  = 0;
   localparam int W_POS_Y  = 1;
   localparam int W_POS_Z  = 2;
   localparam int W_NORM_X = 3;
   localparam int W_NORM_Y = 4;
   localparam int W_NORM_Z = 5;
   localparam int W_TEX_U  = 6;
   localparam int W_TEX_V  = 7;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RAND_PHASES = 6;
   localparam logic [WORD_W-1:0] FLOAT_ONE = 32'h3F80_0000;
   localparam logic [WORD_W-1:0] FLOAT_TWO = 32'h4000_0000;
   localparam logic [WORD_W-1:0] MAX_POS   = 32'h7FFF_FFFF;

   typedef enum {RDY_ALWAYS, RDY_CHOPPY, RDY_LONG_STALL} rsp_pattern_type;

   typedef struct packed {
      logic        new_mesh;
      vdt_key_type comp;
   } corner_type;

   typedef struct packed {
      logic [VIDX_W-1:0] vertex_index;
      logic              was_new;
      logic              table_full;
   } weld_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   vdt_req_if req_bus();
   vdt_rsp_if rsp_bus();

   vertex_dedup_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   corner_type      corner_queue[$];
   weld_type        weld_expect[$];
   vdt_key_type     welded_keys[TABLE_SIZE];
   int unsigned     welded_count = 0;
   logic            cfg_use_normal = 1'b1;
   logic            cfg_use_texcoord = 1'b1;
   rsp_pattern_type rsp_pattern = RDY_ALWAYS;

   int unsigned queued_beats = 0;
   int unsigned taken_beats = 0;
   int unsigned n_new = 0;
   int unsigned n_hit = 0;
   int unsigned n_full = 0;
   int unsigned n_settings = 0;
   int unsigned err_count = 0;
   int unsigned cycles = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic weld_type weld_corner(corner_type c);
      vdt_key_type key;
      weld_type    res;
      bit          found;
      if (c.new_mesh) begin
         welded_count = 0;
      end
      for (int w = 0; w < KEY_WORDS; w++) begin
         key[w] = (c.comp[w] == NEG_ZERO) ? '0 : c.comp[w];
         if (!cfg_use_normal && w >= W_NORM_X && w <= W_NORM_Z) begin
            key[w] = '0;
         end
         if (!cfg_use_texcoord && w >= W_TEX_U) begin
            key[w] = '0;
         end
      end
      res = '0;
      found = 1'b0;
      for (int e = 0; e < int'(welded_count) && !found; e++) begin
         if (welded_keys[e] == key) begin
            res.vertex_index = VIDX_W'(e);
            found = 1'b1;
         end
      end
      if (!found) begin
         if (welded_count >= TABLE_SIZE) begin
            res.table_full = 1'b1;
         end else begin
            welded_keys[welded_count] = key;
            res.vertex_index = VIDX_W'(welded_count);
            res.was_new = 1'b1;
            welded_count++;
         end
      end
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return NEG_ZERO;
         2: return '1;
         3: return FLOAT_ONE;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic corner_type flat_corner(logic nm, logic [WORD_W-1:0] val);
      corner_type c;
      c.new_mesh = nm;
      for (int w = 0; w < KEY_WORDS; w++) begin
         c.comp[w] = val;
      end
      return c;
   endfunction

   function automatic int unsigned next_gap();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         9: return $urandom_range(7, TABLE_SIZE + 2);
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   task automatic push_corner(corner_type c);
      corner_queue.push_back(c);
      queued_beats++;
   endtask

   // Repeats are drawn from the vertices of the current mesh, with zero signs swapped and
   // disabled components scrambled, so that most of them must weld to an earlier index.
   task automatic queue_mesh(int len, int fresh_pct, bit noisy);
      corner_type  c;
      vdt_key_type pool[$];
      int          fw;
      int          fb;
      for (int i = 0; i < len; i++) begin
         c.new_mesh = (i == 0) || (noisy && $urandom_range(0, 29) == 0);
         if (pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
            for (int w = 0; w < KEY_WORDS; w++) begin
               c.comp[w] = rand_word();
            end
            pool.push_back(c.comp);
         end else begin
            c.comp = pool[$urandom_range(0, pool.size() - 1)];
            for (int w = 0; w < KEY_WORDS; w++) begin
               if (c.comp[w] == '0 && $urandom_range(0, 1) == 1) begin
                  c.comp[w] = NEG_ZERO;
               end else if (c.comp[w] == NEG_ZERO && $urandom_range(0, 1) == 1) begin
                  c.comp[w] = '0;
               end
               if (!cfg_use_normal && w >= W_NORM_X && w <= W_NORM_Z &&
                   $urandom_range(0, 1) == 1) begin
                  c.comp[w] = rand_word();
               end
               if (!cfg_use_texcoord && w >= W_TEX_U && $urandom_range(0, 1) == 1) begin
                  c.comp[w] = rand_word();
               end
            end
            if ($urandom_range(0, 9) == 0) begin
               fw = $urandom_range(0, KEY_WORDS - 1);
               fb = $urandom_range(0, WORD_W - 1);
               c.comp[fw][fb] = ~c.comp[fw][fb];
            end
         end
         push_corner(c);
      end
   endtask

   task automatic wait_idle();
      while (taken_beats != queued_beats || weld_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // Called at a rising edge: one write, then a read back of the same register.
   task automatic csr_set(vdt_reg_type r, logic val);
      logic [CSR_DW-1:0] wd;
      logic [CSR_DW-1:0] rd;
      wd = CSR_DW'($urandom);
      wd[0] = val;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * int'(r));
      csr_pwdata  <= wd;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (r == REG_USE_NORMAL) begin
         cfg_use_normal = val;
      end else begin
         cfg_use_texcoord = val;
      end
      n_settings++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== CSR_DW'(val)) begin
         $error("csr_prdata of %s: expected %0h, got %0h", r.name(), CSR_DW'(val), rd);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      corner_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= $urandom_range(1, 8);
         gap_left      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left != 0) begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (corner_queue.size() != 0) begin
            nxt = corner_queue.pop_front();
            req_bus.new_mesh <= nxt.new_mesh;
            req_bus.pos_x    <= nxt.comp[W_POS_X];
            req_bus.pos_y    <= nxt.comp[W_POS_Y];
            req_bus.pos_z    <= nxt.comp[W_POS_Z];
            req_bus.norm_x   <= nxt.comp[W_NORM_X];
            req_bus.norm_y   <= nxt.comp[W_NORM_Y];
            req_bus.norm_z   <= nxt.comp[W_NORM_Z];
            req_bus.tex_u    <= nxt.comp[W_TEX_U];
            req_bus.tex_v    <= nxt.comp[W_TEX_V];
            req_bus.valid    <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 8);
               gap_left   <= next_gap();
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         case (rsp_pattern)
            RDY_CHOPPY: begin
               if ($urandom_range(0, 3) == 0) begin
                  rsp_bus.ready <= 1'b0;
                  stall_left    <= $urandom_range(0, 4);
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
            RDY_LONG_STALL: begin
               if ($urandom_range(0, 99) < 3) begin
                  rsp_bus.ready <= 1'b0;
                  stall_left    <= $urandom_range(10, 100);
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
            default: rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      corner_type got_c;
      weld_type   want;
      weld_type   got;
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("** vertex_dedup_table: FAILED **");
            $finish;
         end else begin
            if (req_bus.valid && req_bus.ready) begin
               got_c.new_mesh       = req_bus.new_mesh;
               got_c.comp[W_POS_X]  = req_bus.pos_x;
               got_c.comp[W_POS_Y]  = req_bus.pos_y;
               got_c.comp[W_POS_Z]  = req_bus.pos_z;
               got_c.comp[W_NORM_X] = req_bus.norm_x;
               got_c.comp[W_NORM_Y] = req_bus.norm_y;
               got_c.comp[W_NORM_Z] = req_bus.norm_z;
               got_c.comp[W_TEX_U]  = req_bus.tex_u;
               got_c.comp[W_TEX_V]  = req_bus.tex_v;
               weld_expect.push_back(weld_corner(got_c));
               taken_beats++;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
               got.vertex_index = rsp_bus.vertex_index;
               got.was_new      = rsp_bus.was_new;
               got.table_full   = rsp_bus.table_full;
               if (weld_expect.size() == 0) begin
                  $error("Result beat with no vertex outstanding: index %0d", got.vertex_index);
                  err_count++;
               end else begin
                  want = weld_expect.pop_front();
                  if (got.vertex_index !== want.vertex_index) begin
                     $error("vertex_index: expected %0d, got %0d",
                            want.vertex_index, got.vertex_index);
                     err_count++;
                  end
                  if (got.was_new !== want.was_new) begin
                     $error("was_new: expected %0b, got %0b", want.was_new, got.was_new);
                     err_count++;
                  end
                  if (got.table_full !== want.table_full) begin
                     $error("table_full: expected %0b, got %0b",
                            want.table_full, got.table_full);
                     err_count++;
                  end
                  if (want.table_full) begin
                     n_full++;
                  end else if (want.was_new) begin
                     n_new++;
                  end else begin
                     n_hit++;
                  end
               end
            end
         end
      end
   end

   initial begin
      corner_type c;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_bus.valid    = 1'b0;
      req_bus.new_mesh = 1'b0;
      req_bus.pos_x    = '0;
      req_bus.pos_y    = '0;
      req_bus.pos_z    = '0;
      req_bus.norm_x   = '0;
      req_bus.norm_y   = '0;
      req_bus.norm_z   = '0;
      req_bus.tex_u    = '0;
      req_bus.tex_v    = '0;
      rsp_bus.ready    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Both components in the key: zero signs, all-ones words, single-word differences.
      csr_set(REG_USE_NORMAL, 1'b1);
      csr_set(REG_USE_TEXCOORD, 1'b1);
      push_corner(flat_corner(1'b1, '0));
      push_corner(flat_corner(1'b0, '1));
      push_corner(flat_corner(1'b0, NEG_ZERO));
      c = flat_corner(1'b0, '0);
      c.comp[W_POS_X] = NEG_ZERO;
      c.comp[W_TEX_V] = NEG_ZERO;
      push_corner(c);
      c = flat_corner(1'b0, '0);
      c.comp[W_TEX_V] = 32'h1;
      push_corner(c);
      c = flat_corner(1'b0, '0);
      c.comp[W_NORM_X] = FLOAT_ONE;
      push_corner(c);
      push_corner(flat_corner(1'b0, '1));
      push_corner(flat_corner(1'b0, MAX_POS));
      push_corner(flat_corner(1'b1, '1));
      push_corner(flat_corner(1'b0, '0));
      wait_idle();

      csr_set(REG_USE_NORMAL, 1'b0);
      push_corner(flat_corner(1'b1, FLOAT_ONE));
      c = flat_corner(1'b0, FLOAT_ONE);
      c.comp[W_NORM_X] = '1;
      c.comp[W_NORM_Y] = '1;
      c.comp[W_NORM_Z] = '1;
      push_corner(c);
      c.comp[W_NORM_Y] = NEG_ZERO;
      c.comp[W_TEX_U] = '1;
      push_corner(c);
      wait_idle();

      csr_set(REG_USE_NORMAL, 1'b1);
      csr_set(REG_USE_TEXCOORD, 1'b0);
      push_corner(flat_corner(1'b1, FLOAT_TWO));
      c = flat_corner(1'b0, FLOAT_TWO);
      c.comp[W_TEX_U] = '1;
      c.comp[W_TEX_V] = NEG_ZERO;
      push_corner(c);
      c.comp[W_NORM_Z] = '1;
      push_corner(c);
      wait_idle();

      csr_set(REG_USE_NORMAL, 1'b0);
      push_corner(flat_corner(1'b1, '1));
      c = flat_corner(1'b0, '0);
      c.comp[W_POS_X] = '1;
      c.comp[W_POS_Y] = '1;
      c.comp[W_POS_Z] = '1;
      c.comp[W_TEX_U] = MAX_POS;
      push_corner(c);
      c = flat_corner(1'b0, FLOAT_ONE);
      c.comp[W_POS_X] = NEG_ZERO;
      push_corner(c);
      c.comp[W_POS_X] = '0;
      c.comp[W_NORM_Y] = '1;
      push_corner(c);
      wait_idle();

      // One mesh long enough to fill the table, with repeats before and after it fills.
      csr_set(REG_USE_NORMAL, 1'b1);
      csr_set(REG_USE_TEXCOORD, 1'b1);
      rsp_pattern = RDY_CHOPPY;
      queue_mesh(340, 82, 1'b0);
      wait_idle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         csr_set(REG_USE_NORMAL, (p < 4) ? p[1] : 1'($urandom_range(0, 1)));
         csr_set(REG_USE_TEXCOORD, (p < 4) ? p[0] : 1'($urandom_range(0, 1)));
         rsp_pattern = rsp_pattern_type'(p % 3);
         repeat (3) queue_mesh($urandom_range(4, 28), 45, 1'b1);
         wait_idle();
      end

      repeat (TABLE_SIZE + 4) @(posedge clock);
      $display("Welded %0d vertex beats under %0d register settings: %0d stored, %0d matched,",
               taken_beats, n_settings, n_new, n_hit);
      $display("and %0d refused on a full table, across directed and random meshes.", n_full);
      if (err_count == 0) begin
         $display("** vertex_dedup_table: PASSED **");
      end else begin
         $display("** vertex_dedup_table: FAILED **");
      end
      $finish;
   end
endmodule
